// ===== src/spl_pkg.sv =====
// shared types and constants for the slotted page record lookup unit
`default_nettype none

package spl_pkg;

	// request codes
	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	// page layout
	localparam int unsigned HDR_BYTES     = 64;
	localparam int unsigned SLOT_BYTES    = 4;
	localparam int unsigned REC_HDR_BYTES = 5;
	localparam logic [7:0]  META_DELETED  = 8'h01;

	// byte counts of the three gathers
	localparam logic [2:0] CNT_NBYTES = 3'd2;
	localparam logic [2:0] ENT_NBYTES = 3'd4;
	localparam logic [2:0] HDR_NBYTES = 3'd5;

	// gather shift register width (longest gather)
	localparam int unsigned GATH_W = 40;

	// internal address arithmetic width
	localparam int unsigned SUM_W = 20;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_RANGE    = 2'd1,
		ST_CORRUPT  = 2'd2,
		ST_DELETED  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CHK_CNT,
		S_CHK_ENT,
		S_CHK_HDR
	} state_t;

	typedef enum logic [1:0] {
		PH_CNT,
		PH_ENT,
		PH_HDR
	} phase_t;

endpackage

`default_nettype wire

// ===== src/slotted_page_record_lookup_unit.sv =====
// slotted page record lookup: page byte store, slot and record header walk
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------------------
//  in      | in  | in_valid / in_stall | action, byte_address, byte_value, slot_index
//  out     | out | out_valid/out_stall | status, key_offset, key_length, value_offset,
//          |     |                     | value_length
//
// A write request stores its byte when accepted. A lookup reads 2 count, 4 slot entry
// and 5 header bytes one by one through the single ram port; each gather waits on the
// registered ram read, then a check state follows. A slot out of range or an entry past
// the page end ends the walk at the count check, bad record bounds at the entry check.
// in_stall is high while a lookup walks the page or its result waits for a free output
// register. Reset clears control state only; page bytes are undefined until written.
`default_nettype none

module slotted_page_record_lookup_unit #(
	parameter int PAGE_BYTES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        action,
	input  wire logic [11:0] byte_address,
	input  wire logic [7:0]  byte_value,
	input  wire logic [15:0] slot_index,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [12:0]      key_offset,
	output logic [15:0]      key_length,
	output logic [16:0]      value_offset,
	output logic [15:0]      value_length
);

	localparam int AW = $clog2(PAGE_BYTES);
	localparam logic [spl_pkg::SUM_W-1:0] PAGE_LIM = spl_pkg::SUM_W'(PAGE_BYTES);
	localparam logic [spl_pkg::SUM_W-1:0] CNT_ADDR = spl_pkg::SUM_W'(spl_pkg::HDR_BYTES);
	localparam logic [spl_pkg::SUM_W-1:0] ENT_END_BASE =
		spl_pkg::SUM_W'(spl_pkg::HDR_BYTES + 2 + spl_pkg::SLOT_BYTES);
	localparam logic [spl_pkg::SUM_W-1:0] SLOT_SZ = spl_pkg::SUM_W'(spl_pkg::SLOT_BYTES);
	localparam logic [spl_pkg::SUM_W-1:0] RHDR_SZ = spl_pkg::SUM_W'(spl_pkg::REC_HDR_BYTES);

	// control registers
	spl_pkg::state_t state_q, state_d;
	spl_pkg::phase_t phase_q;
	logic [2:0]      issued_q;
	logic [2:0]      got_q;
	logic [2:0]      need_q;
	logic            pend_q;
	logic            out_valid_q;

	// payload registers
	logic [AW-1:0]                 ptr_q;
	logic [spl_pkg::GATH_W-1:0]    gath_q;
	logic [15:0]                   slot_q;
	logic [15:0]                   roff_q;
	logic [1:0]                    status_q;
	logic [12:0]                   koff_q;
	logic [15:0]                   klen_q;
	logic [16:0]                   voff_q;
	logic [15:0]                   vlen_q;

	// ram port
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [7:0]    ram_rdata;

	// handshakes
	logic in_fire;
	logic out_free;

	// shared adder
	logic [spl_pkg::SUM_W-1:0] add_a, add_b, sum;

	// sequencer outputs
	logic                      issue;
	logic                      last_byte;
	logic                      start_rd;
	logic [AW-1:0]             start_ptr;
	logic [2:0]                start_need;
	spl_pkg::phase_t           start_phase;
	logic                      finish;
	spl_pkg::status_t          res_status;
	logic [12:0]               res_koff;
	logic [15:0]               res_klen;
	logic [16:0]               res_voff;
	logic [15:0]               res_vlen;

	// gathered views
	logic [15:0]               count_w;
	logic [15:0]               ent_off_w;
	logic [15:0]               ent_len_w;
	logic [7:0]                meta_w;
	logic [15:0]               hdr_klen_w;
	logic [15:0]               hdr_vlen_w;
	logic [spl_pkg::SUM_W-1:0] koff_w;
	logic [spl_pkg::SUM_W-1:0] wr_addr_w;

	assign in_stall  = (state_q != spl_pkg::S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign count_w    = gath_q[39:24];
	assign ent_off_w  = gath_q[23:8];
	assign ent_len_w  = gath_q[39:24];
	assign meta_w     = gath_q[7:0];
	assign hdr_klen_w = gath_q[23:8];
	assign hdr_vlen_w = gath_q[39:24];
	assign koff_w     = spl_pkg::SUM_W'(roff_q) + RHDR_SZ;
	assign wr_addr_w  = spl_pkg::SUM_W'(byte_address);

	// page store
	spl_ram #(
		.WIDTH (8),
		.DEPTH (PAGE_BYTES)
	) u_page (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (byte_value),
		.rdata (ram_rdata)
	);

	assign ram_we   = in_fire && (action == spl_pkg::ACT_WRITE) && (wr_addr_w < PAGE_LIM);
	assign ram_addr = (state_q == spl_pkg::S_IDLE) ? wr_addr_w[AW-1:0] : ptr_q;

	// shared adder operand select
	always_comb begin
		add_a = '0;
		add_b = '0;
		unique case (state_q)
			spl_pkg::S_READ: begin
				add_a = spl_pkg::SUM_W'(ptr_q);
				add_b = spl_pkg::SUM_W'(1);
			end
			spl_pkg::S_CHK_CNT: begin
				add_a = spl_pkg::SUM_W'({slot_q, 2'b00});
				add_b = ENT_END_BASE;
			end
			spl_pkg::S_CHK_ENT: begin
				add_a = spl_pkg::SUM_W'(ent_off_w);
				add_b = spl_pkg::SUM_W'(ent_len_w);
			end
			spl_pkg::S_CHK_HDR: begin
				add_a = koff_w;
				add_b = spl_pkg::SUM_W'(hdr_klen_w);
			end
			default: begin
				add_a = '0;
				add_b = '0;
			end
		endcase
	end

	assign sum = add_a + add_b;

	// gather progress
	assign issue     = (state_q == spl_pkg::S_READ) && (issued_q != need_q);
	assign last_byte = (state_q == spl_pkg::S_READ) && pend_q && (got_q == need_q - 3'd1);

	// sequencer outputs
	always_comb begin
		start_rd    = 1'b0;
		start_ptr   = '0;
		start_need  = spl_pkg::CNT_NBYTES;
		start_phase = spl_pkg::PH_CNT;
		finish      = 1'b0;
		res_status  = spl_pkg::ST_OK;
		res_koff    = '0;
		res_klen    = '0;
		res_voff    = '0;
		res_vlen    = '0;
		unique case (state_q)
			spl_pkg::S_IDLE: begin
				if (in_fire && action == spl_pkg::ACT_LOOKUP) begin
					start_rd    = 1'b1;
					start_ptr   = CNT_ADDR[AW-1:0];
					start_need  = spl_pkg::CNT_NBYTES;
					start_phase = spl_pkg::PH_CNT;
				end
			end
			spl_pkg::S_READ: begin
			end
			spl_pkg::S_CHK_CNT: begin
				priority if (slot_q >= count_w) begin
					finish     = 1'b1;
					res_status = spl_pkg::ST_RANGE;
				end else if (sum > PAGE_LIM) begin
					finish     = 1'b1;
					res_status = spl_pkg::ST_CORRUPT;
				end else begin
					start_rd    = 1'b1;
					start_ptr   = AW'(sum - SLOT_SZ);
					start_need  = spl_pkg::ENT_NBYTES;
					start_phase = spl_pkg::PH_ENT;
				end
			end
			spl_pkg::S_CHK_ENT: begin
				if (spl_pkg::SUM_W'(ent_off_w) >= PAGE_LIM || sum > PAGE_LIM ||
				    spl_pkg::SUM_W'(ent_off_w) + RHDR_SZ > PAGE_LIM) begin
					finish     = 1'b1;
					res_status = spl_pkg::ST_CORRUPT;
				end else begin
					start_rd    = 1'b1;
					start_ptr   = AW'(ent_off_w);
					start_need  = spl_pkg::HDR_NBYTES;
					start_phase = spl_pkg::PH_HDR;
				end
			end
			spl_pkg::S_CHK_HDR: begin
				finish = 1'b1;
				if (meta_w == spl_pkg::META_DELETED) begin
					res_status = spl_pkg::ST_DELETED;
				end else begin
					res_status = spl_pkg::ST_OK;
					res_koff   = koff_w[12:0];
					res_klen   = hdr_klen_w;
					res_voff   = sum[16:0];
					res_vlen   = hdr_vlen_w;
				end
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spl_pkg::S_IDLE: begin
				if (start_rd) begin
					state_d = spl_pkg::S_READ;
				end
			end
			spl_pkg::S_READ: begin
				if (last_byte) begin
					unique case (phase_q)
						spl_pkg::PH_CNT: state_d = spl_pkg::S_CHK_CNT;
						spl_pkg::PH_ENT: state_d = spl_pkg::S_CHK_ENT;
						spl_pkg::PH_HDR: state_d = spl_pkg::S_CHK_HDR;
						default:         state_d = spl_pkg::S_IDLE;
					endcase
				end
			end
			spl_pkg::S_CHK_CNT, spl_pkg::S_CHK_ENT, spl_pkg::S_CHK_HDR: begin
				priority if (start_rd) begin
					state_d = spl_pkg::S_READ;
				end else if (finish && out_free) begin
					state_d = spl_pkg::S_IDLE;
				end else begin
					state_d = state_q;
				end
			end
			default: state_d = spl_pkg::S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spl_pkg::S_IDLE;
			phase_q     <= spl_pkg::PH_CNT;
			issued_q    <= '0;
			got_q       <= '0;
			need_q      <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_rd) begin
				phase_q  <= start_phase;
				need_q   <= start_need;
				issued_q <= '0;
				got_q    <= '0;
				pend_q   <= 1'b0;
			end else begin
				pend_q <= issue;
				if (issue) begin
					issued_q <= issued_q + 3'd1;
				end
				if (state_q == spl_pkg::S_READ && pend_q) begin
					got_q <= got_q + 3'd1;
				end
			end
			// result register
			if (finish && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			slot_q <= slot_index;
		end
		if (start_rd) begin
			ptr_q <= start_ptr;
		end else if (issue) begin
			ptr_q <= sum[AW-1:0];
		end
		if (state_q == spl_pkg::S_READ && pend_q) begin
			gath_q <= {ram_rdata, gath_q[spl_pkg::GATH_W-1:8]};
		end
		if (state_q == spl_pkg::S_CHK_ENT) begin
			roff_q <= ent_off_w;
		end
		if (finish && out_free) begin
			status_q <= res_status;
			koff_q   <= res_koff;
			klen_q   <= res_klen;
			voff_q   <= res_voff;
			vlen_q   <= res_vlen;
		end
	end

	assign status       = status_q;
	assign key_offset   = koff_q;
	assign key_length   = klen_q;
	assign value_offset = voff_q;
	assign value_length = vlen_q;

	// a new result only appears right after a check cycle
	a_result_from_check: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == spl_pkg::S_CHK_CNT ||
		                      $past(state_q) == spl_pkg::S_CHK_ENT ||
		                      $past(state_q) == spl_pkg::S_CHK_HDR))
		else $error("result raised outside a check cycle");

	// page writes never disturb a lookup walk
	a_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == spl_pkg::S_IDLE)
		else $error("page write during lookup");

	// failed lookups carry zero fields
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != spl_pkg::ST_OK) |->
		(key_offset == 13'd0 && key_length == 16'd0 &&
		 value_offset == 17'd0 && value_length == 16'd0))
		else $error("nonzero fields on failed lookup");

	// a read in flight only exists while gathering
	a_pend_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> $past(state_q) == spl_pkg::S_READ)
		else $error("ram read pending outside gather");

endmodule

`default_nettype wire

// ===== src/spl_ram.sv =====
// generic single-port ram with registered read
`default_nettype none

module spl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire
